### rtl/core/ipte_pkg.sv
// ----------------------------------------------------------------------------
// ipte_pkg
// Types, constants and helpers shared by the IPv4 prefix store engine.
// ----------------------------------------------------------------------------
package ipte_pkg;

  localparam int ENTRIES   = 64;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int PTR_W     = $clog2(ENTRIES + 1);
  localparam int KEY_W     = 32;
  localparam int LEN_W     = 6;
  localparam int VALUE_W   = 16;
  localparam int STATUS_W  = 3;
  localparam int CMD_W     = 2;
  localparam int MAX_LEN   = 32;
  localparam int NLEN      = MAX_LEN + 1;
  localparam int IN_DATA_W = 56;
  localparam int OUT_DATA_W = 32;

  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_MATCH     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_MATCH  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_DRAIN,
    S_COMMIT,
    S_NOMATCH,
    S_SCAN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [LEN_W-1:0]   len;
    logic [VALUE_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic                start;
    logic                sweep;
    logic                commit;
    logic                vread;
    logic                lvl_inc;
    logic                out_single;
    logic                out_match;
    logic [STATUS_W-1:0] single_status;
  } dp_cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic req_search;
    logic req_add;
    logic any_hit;
    logic lvl_hit;
    logic is_last;
    logic found;
    logic free_found;
    logic out_free;
  } dp_status_t;

  function automatic logic [KEY_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    len_mask = ~({KEY_W{1'b1}} >> len);
  endfunction

endpackage

### rtl/core/ipte_ctrl.sv
// ----------------------------------------------------------------------------
// ipte_ctrl
// Sequencer for sweep, commit and result emission of the prefix engine.
// ----------------------------------------------------------------------------
module ipte_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [ipte_pkg::CMD_W-1:0] in_command,
  output logic                       in_ready,
  input  ipte_pkg::dp_status_t       stat,
  output ipte_pkg::dp_cmd_t          cmd
);
  import ipte_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          if (in_command == CMD_SEARCH || in_command == CMD_ADD ||
              in_command == CMD_DELETE) begin
            state_next = S_SWEEP;
          end
        end
      end
      S_SWEEP: begin
        if (!stat.sweep_done) begin
          cmd.sweep = 1'b1;
        end else begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat.req_search) begin
          state_next = S_COMMIT;
        end else if (stat.any_hit) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_NOMATCH;
        end
      end
      S_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit     = 1'b1;
          cmd.out_single = 1'b1;
          if (stat.req_add) begin
            cmd.single_status = (stat.found || stat.free_found) ? ST_ADDED : ST_FULL;
          end else begin
            cmd.single_status = stat.found ? ST_DELETED : ST_NOT_FOUND;
          end
          state_next = S_IDLE;
        end
      end
      S_NOMATCH: begin
        if (stat.out_free) begin
          cmd.out_single    = 1'b1;
          cmd.single_status = ST_NO_MATCH;
          state_next        = S_IDLE;
        end
      end
      S_SCAN: begin
        if (stat.lvl_hit) begin
          cmd.vread  = 1'b1;
          state_next = S_EMIT;
        end else begin
          cmd.lvl_inc = 1'b1;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_match = 1'b1;
          if (stat.is_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.lvl_inc = 1'b1;
            state_next  = S_SCAN;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### rtl/core/ipte_datapath.sv
// ----------------------------------------------------------------------------
// ipte_datapath
// Prefix store memory, sweep compare, hit collection and output register.
// ----------------------------------------------------------------------------
module ipte_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [ipte_pkg::CMD_W-1:0]      in_command,
  input  logic [ipte_pkg::KEY_W-1:0]      in_key,
  input  logic [ipte_pkg::LEN_W-1:0]      in_len,
  input  logic [ipte_pkg::VALUE_W-1:0]    in_value,
  input  ipte_pkg::dp_cmd_t               cmd,
  output ipte_pkg::dp_status_t            stat,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ipte_pkg::STATUS_W-1:0]   out_status,
  output logic [ipte_pkg::VALUE_W-1:0]    out_value,
  output logic [ipte_pkg::LEN_W-1:0]      out_length,
  output logic                            out_last
);
  import ipte_pkg::*;

  entry_t                store_mem [ENTRIES];
  logic [ENTRIES-1:0]    valid;
  logic [VALUE_W-1:0]    vbuf [NLEN];

  logic [CMD_W-1:0]      req_cmd;
  logic [KEY_W-1:0]      req_addr;
  logic [KEY_W-1:0]      req_key;
  logic [LEN_W-1:0]      req_len;
  logic [VALUE_W-1:0]    req_value;

  logic [PTR_W-1:0]      sweep_ptr;
  logic                  rd_pending;
  entry_t                rd_data;
  logic [IDX_W-1:0]      rd_idx;
  logic                  found;
  logic [IDX_W-1:0]      found_idx;
  logic                  free_found;
  logic [IDX_W-1:0]      free_idx;
  logic [NLEN-1:0]       hits;
  logic [LEN_W-1:0]      lvl;
  logic [VALUE_W-1:0]    vrd;

  logic [LEN_W-1:0]      len_clamped;
  logic                  rd_valid;
  logic                  covers;
  logic                  exact;
  logic                  commit_write;
  logic [IDX_W-1:0]      commit_idx;

  assign len_clamped = (in_len > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : in_len;
  assign rd_valid    = rd_pending && valid[rd_idx];
  assign covers      = (rd_data.len <= LEN_W'(MAX_LEN)) &&
                       (rd_data.key == (req_addr & len_mask(rd_data.len)));
  assign exact       = (rd_data.len == req_len) && (rd_data.key == req_key);

  assign commit_write = cmd.commit && (req_cmd == CMD_ADD) && (found || free_found);
  assign commit_idx   = found ? found_idx : free_idx;

  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      rd_data <= store_mem[sweep_ptr[IDX_W-1:0]];
    end
    if (commit_write) begin
      store_mem[commit_idx] <= '{key: req_key, len: req_len, value: req_value};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid && req_cmd == CMD_SEARCH && covers) begin
      vbuf[rd_data.len] <= rd_data.value;
    end
    if (cmd.vread) begin
      vrd <= vbuf[lvl];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.commit) begin
      if (req_cmd == CMD_ADD && (found || free_found)) begin
        valid[commit_idx] <= 1'b1;
      end else if (req_cmd == CMD_DELETE && found) begin
        valid[found_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
      sweep_ptr  <= '0;
    end else begin
      rd_pending <= cmd.sweep;
      if (cmd.start) begin
        sweep_ptr <= '0;
      end else if (cmd.sweep) begin
        sweep_ptr <= sweep_ptr + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      rd_idx <= sweep_ptr[IDX_W-1:0];
    end
    if (cmd.start) begin
      req_cmd    <= in_command;
      req_addr   <= in_key;
      req_len    <= len_clamped;
      req_key    <= in_key & len_mask(len_clamped);
      req_value  <= in_value;
      found      <= 1'b0;
      free_found <= 1'b0;
      hits       <= '0;
      lvl        <= '0;
    end else begin
      if (rd_pending) begin
        if (!valid[rd_idx] && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= rd_idx;
        end
        if (rd_valid && req_cmd != CMD_SEARCH && exact) begin
          found     <= 1'b1;
          found_idx <= rd_idx;
        end
        if (rd_valid && req_cmd == CMD_SEARCH && covers) begin
          hits[rd_data.len] <= 1'b1;
        end
      end
      if (cmd.lvl_inc) begin
        lvl <= lvl + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_single || cmd.out_match) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_single) begin
      out_status <= cmd.single_status;
      out_value  <= '0;
      out_length <= '0;
      out_last   <= 1'b1;
    end else if (cmd.out_match) begin
      out_status <= ST_MATCH;
      out_value  <= vrd;
      out_length <= lvl;
      out_last   <= stat.is_last;
    end
  end

  assign stat.sweep_done = (sweep_ptr == PTR_W'(ENTRIES));
  assign stat.req_search = (req_cmd == CMD_SEARCH);
  assign stat.req_add    = (req_cmd == CMD_ADD);
  assign stat.any_hit    = |hits;
  assign stat.lvl_hit    = hits[lvl];
  assign stat.is_last    = ((hits >> lvl) == NLEN'(1));
  assign stat.found      = found;
  assign stat.free_found = free_found;
  assign stat.out_free   = !out_valid || out_ready;

endmodule

### rtl/core/ipv4_prefix_trie_engine_top.sv
// ----------------------------------------------------------------------------
// ipv4_prefix_trie_engine_top
// IPv4 prefix store with all-covering-prefix search, add and delete.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  s_*     | in  | tdata: command[1:0] address_key[33:2] prefix_length[39:34]
//          |     |        entry_value[55:40]
//  m_*     | out | tdata: status[2:0] match_value[18:3] match_length[24:19];
//          |     | tlast: last
//
//  Each item sweeps all 64 store entries through one memory read port,
//  then add/delete commits and a search emits one result per covering
//  prefix length, shortest first. Reset marks every entry invalid at once.
//  A stalled output holds the sequencer; a new item is taken once the
//  previous one has emitted all.
// ----------------------------------------------------------------------------
module ipv4_prefix_trie_engine_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [ipte_pkg::IN_DATA_W-1:0]      s_tdata,   // command, address_key, prefix_length, entry_value
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [ipte_pkg::OUT_DATA_W-1:0]     m_tdata,   // status, match_value, match_length, zero fill
  output logic                                m_tlast
);
  import ipte_pkg::*;

  dp_cmd_t             cmd;
  dp_status_t          stat;
  logic [STATUS_W-1:0] out_status;
  logic [VALUE_W-1:0]  out_value;
  logic [LEN_W-1:0]    out_length;

  ipte_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_command (s_tdata[1:0]),
    .in_ready   (s_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  ipte_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .in_command (s_tdata[1:0]),
    .in_key     (s_tdata[33:2]),
    .in_len     (s_tdata[39:34]),
    .in_value   (s_tdata[55:40]),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (out_status),
    .out_value  (out_value),
    .out_length (out_length),
    .out_last   (m_tlast)
  );

  assign m_tdata = {7'd0, out_length, out_value, out_status};

endmodule

### rtl/core/ipte_checker.sv
// ----------------------------------------------------------------------------
// ipte_checker
// Port-level checks on the prefix engine result stream.
// ----------------------------------------------------------------------------
module ipte_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast
);
  import ipte_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] != ST_MATCH |-> m_tlast)
    else $error("non-match result without last");

  a_single_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] != ST_MATCH |-> m_tdata[31:3] == '0)
    else $error("non-match result carries value or length");

endmodule

bind ipv4_prefix_trie_engine_top ipte_checker u_ipte_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
